// File: sv/fqd_pkg.sv
// Shared types and constants for the FIFO queue with delete.
// Request and response payload structs, opcodes and status codes.
// No dependencies.
package fqd_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int ITEM_WIDTH_DEF = 32;
   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 5;

   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_DEL = 2'd2,
      OP_LEN = 2'd3
   } fqd_op_type;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      fqd_op_type           opcode;
      logic [VALUE_W-1:0]   item_value;
   } fqd_req_type;

   typedef struct packed {
      logic                 status;
      logic [VALUE_W-1:0]   item_out;
      logic [COUNT_W-1:0]   entry_count;
   } fqd_rsp_type;

endpackage

// File: sv/fqd_store.sv
// Entry storage for the FIFO queue with delete.
// One write port and one read port with registered read data.
// Depends on fqd_pkg for default sizes.
module fqd_store #(
   parameter int DEPTH = fqd_pkg::CAPACITY_DEF,
   parameter int WIDTH = fqd_pkg::ITEM_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fifo_queue_with_delete.sv
// Top level of the bounded FIFO queue of item handles with delete-by-value.
// Depends on fqd_pkg and fqd_store.
//
// Usage:
//   Request channel: req_data (opcode, item_value) is taken when start is high
//   and busy is low. Response channel: rsp_data is valid for exactly one cycle
//   while rsp_strobe is high; the receiver cannot stall it.
//   Enqueue appends a nonzero handle, dequeue returns the oldest handle, delete
//   removes the oldest entry equal to a nonzero handle, length reports the count.
// Timing:
//   Enqueue, length query, empty dequeue and null or empty delete: result registered in
//   the cycle after the transfer, busy stays low, so one such request can follow every cycle.
//   Dequeue: result after one storage read and the response register, busy high one cycle.
//   Delete: the storage read and write ports are walked by a small sequencer, a read
//   and a compare state per entry scanned oldest first and a read and a write state per
//   later entry shifted down, then the response register; busy is high meanwhile.
// Reset:
//   Synchronous reset empties the queue and returns to idle; stored entries are
//   not cleared and are only read after they are written again.
module fifo_queue_with_delete #(
   parameter int CAPACITY   = fqd_pkg::CAPACITY_DEF,
   parameter int ITEM_WIDTH = fqd_pkg::ITEM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fqd_pkg::fqd_req_type req_data,
   output logic                 busy,
   output logic                 rsp_strobe,
   output fqd_pkg::fqd_rsp_type rsp_data
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DEQ      = 6'b000010,
      ST_SCAN_RD  = 6'b000100,
      ST_SCAN_CMP = 6'b001000,
      ST_SHIFT_RD = 6'b010000,
      ST_SHIFT_WR = 6'b100000
   } state_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] prev_ptr(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : p - PTR_W'(1);
   endfunction

   function automatic fqd_pkg::fqd_rsp_type make_rsp(
      input logic                          status,
      input logic [fqd_pkg::VALUE_W-1:0]   item,
      input logic [CNT_W-1:0]              cnt
   );
      fqd_pkg::fqd_rsp_type r;
      r.status      = status;
      r.item_out    = item;
      r.entry_count = fqd_pkg::COUNT_W'(cnt);
      return r;
   endfunction

   state_type                  state_ff, state_in;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [PTR_W-1:0]           pos_ff, pos_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [ITEM_WIDTH-1:0]      target_ff, target_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   fqd_pkg::fqd_rsp_type       rsp_data_ff, rsp_data_in;

   logic [ITEM_WIDTH-1:0]      in_val;
   logic                       wr_en;
   logic [PTR_W-1:0]           wr_addr;
   logic [ITEM_WIDTH-1:0]      wr_data;
   logic                       rd_en;
   logic [PTR_W-1:0]           rd_addr;
   logic [ITEM_WIDTH-1:0]      rd_data;

   assign in_val = ITEM_WIDTH'(req_data.item_value);

   fqd_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ITEM_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      target_in     = target_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;
      wr_data       = in_val;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.opcode)
                  fqd_pkg::OP_ENQ: begin
                     rsp_strobe_in = 1'b1;
                     if (in_val != '0 && count_ff != CNT_FULL) begin
                        wr_en       = 1'b1;
                        tail_in     = next_ptr(tail_ff);
                        count_in    = count_ff + CNT_ONE;
                        rsp_data_in = make_rsp(fqd_pkg::STATUS_OK, '0, count_ff + CNT_ONE);
                     end else begin
                        rsp_data_in = make_rsp(fqd_pkg::STATUS_REJECT, '0, count_ff);
                     end
                  end
                  fqd_pkg::OP_DEQ: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = ST_DEQ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_data_in   = make_rsp(fqd_pkg::STATUS_REJECT, '0, count_ff);
                     end
                  end
                  fqd_pkg::OP_DEL: begin
                     if (in_val != '0 && count_ff != '0) begin
                        target_in = in_val;
                        pos_in    = head_ff;
                        idx_in    = '0;
                        state_in  = ST_SCAN_RD;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_data_in   = make_rsp(fqd_pkg::STATUS_REJECT, '0, count_ff);
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = make_rsp(fqd_pkg::STATUS_OK, '0, count_ff);
                  end
               endcase
            end
         end
         ST_DEQ: begin
            head_in       = next_ptr(head_ff);
            count_in      = count_ff - CNT_ONE;
            rsp_strobe_in = 1'b1;
            rsp_data_in   = make_rsp(fqd_pkg::STATUS_OK, fqd_pkg::VALUE_W'(rd_data),
                                     count_ff - CNT_ONE);
            state_in      = ST_IDLE;
         end
         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = pos_ff;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (rd_data == target_ff) begin
               if (idx_ff == count_ff - CNT_ONE) begin
                  count_in      = count_ff - CNT_ONE;
                  tail_in       = prev_ptr(tail_ff);
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = make_rsp(fqd_pkg::STATUS_OK, '0, count_ff - CNT_ONE);
                  state_in      = ST_IDLE;
               end else begin
                  idx_in   = count_ff - CNT_ONE - idx_ff;
                  state_in = ST_SHIFT_RD;
               end
            end else if (idx_ff == count_ff - CNT_ONE) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = make_rsp(fqd_pkg::STATUS_REJECT, '0, count_ff);
               state_in      = ST_IDLE;
            end else begin
               idx_in   = idx_ff + CNT_ONE;
               pos_in   = next_ptr(pos_ff);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = next_ptr(pos_ff);
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = rd_data;
            pos_in  = next_ptr(pos_ff);
            idx_in  = idx_ff - CNT_ONE;
            if (idx_ff == CNT_ONE) begin
               count_in      = count_ff - CNT_ONE;
               tail_in       = prev_ptr(tail_ff);
               rsp_strobe_in = 1'b1;
               rsp_data_in   = make_rsp(fqd_pkg::STATUS_OK, '0, count_ff - CNT_ONE);
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      target_ff   <= target_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count above capacity");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) || (count_ff == CNT_FULL)) == (head_ff == tail_ff))
      else $error("head and tail pointers disagree with entry count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((count_ff == $past(count_ff)) ||
                         (count_ff == $past(count_ff) + CNT_ONE) ||
                         (count_ff + CNT_ONE == $past(count_ff))))
      else $error("entry count changed by more than one");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy)
      else $error("response issued while sequencer busy");

   a_busy_ends_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe_ff)
      else $error("multi-cycle request finished without a response");
`endif

endmodule

// File: bench/fifo_queue_with_delete_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for fifo_queue_with_delete: directed corner requests, then
// random enqueue/dequeue/delete/length traffic scored against a queue predictor.
// Depends on fqd_pkg and the fifo_queue_with_delete RTL.
module fifo_queue_with_delete_tb;

   localparam int CAPACITY    = fqd_pkg::CAPACITY_DEF;
   localparam int ITEM_W      = fqd_pkg::ITEM_WIDTH_DEF;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE      = 80;
   localparam int PHASE_ITEMS = 483;
   localparam logic [fqd_pkg::VALUE_W-1:0] ITEM_MASK =
      {fqd_pkg::VALUE_W{1'b1}} >> (fqd_pkg::VALUE_W - ITEM_W);

   class queue_scoreboard;
      logic [fqd_pkg::VALUE_W-1:0] held[$];
      fqd_pkg::fqd_rsp_type        expected[$];
      int                          errors = 0;

      function void note_request(fqd_pkg::fqd_req_type r);
         fqd_pkg::fqd_rsp_type        e;
         logic [fqd_pkg::VALUE_W-1:0] v;
         v = r.item_value & ITEM_MASK;
         e.status   = fqd_pkg::STATUS_REJECT;
         e.item_out = '0;
         case (r.opcode)
            fqd_pkg::OP_ENQ: begin
               if (v != '0 && held.size() < CAPACITY) begin
                  held.push_back(v);
                  e.status = fqd_pkg::STATUS_OK;
               end
            end
            fqd_pkg::OP_DEQ: begin
               if (held.size() > 0) begin
                  e.item_out = held.pop_front();
                  e.status   = fqd_pkg::STATUS_OK;
               end
            end
            fqd_pkg::OP_DEL: begin
               if (v != '0) begin
                  for (int k = 0; k < held.size(); k++) begin
                     if (held[k] == v) begin
                        held.delete(k);
                        e.status = fqd_pkg::STATUS_OK;
                        break;
                     end
                  end
               end
            end
            default: e.status = fqd_pkg::STATUS_OK;
         endcase
         e.entry_count = fqd_pkg::COUNT_W'(held.size());
         expected.push_back(e);
      endfunction

      function void check_response(fqd_pkg::fqd_rsp_type a);
         fqd_pkg::fqd_rsp_type e;
         if (expected.size() == 0) begin
            $error("response transfer with nothing expected: status %0d item %h count %0d",
                   a.status, a.item_out, a.entry_count);
            errors++;
            return;
         end
         e = expected.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
         end
         if (a.item_out !== e.item_out) begin
            $error("item_out: expected %h, got %h", e.item_out, a.item_out);
            errors++;
         end
         if (a.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, got %0d", e.entry_count, a.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   fqd_pkg::fqd_req_type req_data;
   logic                 busy;
   logic                 rsp_strobe;
   fqd_pkg::fqd_rsp_type rsp_data;

   queue_scoreboard sb = new();
   int              stall_cycles;
   int              enq_bias;

   fifo_queue_with_delete #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5 clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_strobe) sb.check_response(rsp_data);
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("fifo_queue_with_delete_tb: errors");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   function automatic fqd_pkg::fqd_req_type pick_request();
      fqd_pkg::fqd_req_type r;
      int                   roll;
      int                   n;
      n    = sb.held.size();
      roll = $urandom_range(99);
      r.item_value = ($urandom_range(3) == 0) ?
                     fqd_pkg::VALUE_W'($urandom_range(1, 24)) : $urandom;
      if (roll < enq_bias)
         r.opcode = fqd_pkg::OP_ENQ;
      else if (roll < enq_bias + (100 - enq_bias) / 2)
         r.opcode = fqd_pkg::OP_DEQ;
      else if (roll < 96)
         r.opcode = fqd_pkg::OP_DEL;
      else
         r.opcode = fqd_pkg::OP_LEN;
      if (r.opcode == fqd_pkg::OP_DEL && n > 0 && $urandom_range(3) != 0)
         r.item_value = sb.held[$urandom_range(n - 1)];
      if ($urandom_range(49) == 0) r.item_value = '0;
      return r;
   endfunction

   task automatic send(input int idle_pct, input bit pick, input fqd_pkg::fqd_op_type op,
                       input logic [fqd_pkg::VALUE_W-1:0] val);
      fqd_pkg::fqd_req_type r;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      if (pick) begin
         r = pick_request();
      end else begin
         r.opcode     = op;
         r.item_value = val;
      end
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
   endtask

   // hold off new requests until every outstanding response has arrived
   task automatic drain_wait();
      @(negedge clock);
      start = 1'b0;
      while (sb.expected.size() != 0) @(negedge clock);
   endtask

   initial begin
      int idle_pct[3];
      idle_pct = '{16, 57, 0};
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      enq_bias = 50;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(0, 0, fqd_pkg::OP_LEN, '0);
      send(0, 0, fqd_pkg::OP_DEQ, '0);
      send(0, 0, fqd_pkg::OP_DEL, 32'h0000_1234);
      send(0, 0, fqd_pkg::OP_ENQ, '0);
      send(0, 0, fqd_pkg::OP_DEL, '0);
      send(0, 0, fqd_pkg::OP_ENQ, 32'hFFFF_FFFF);
      send(0, 0, fqd_pkg::OP_ENQ, 32'h0000_0001);
      send(0, 0, fqd_pkg::OP_ENQ, 32'h8000_0000);
      send(0, 0, fqd_pkg::OP_ENQ, 32'h0000_0001);
      send(0, 0, fqd_pkg::OP_DEL, 32'h0000_0001);
      send(0, 0, fqd_pkg::OP_DEL, 32'hDEAD_BEEF);
      send(0, 0, fqd_pkg::OP_DEQ, '0);
      for (int k = 3; k <= CAPACITY; k++)
         send(0, 0, fqd_pkg::OP_ENQ, fqd_pkg::VALUE_W'(32'h1000 + k));
      send(0, 0, fqd_pkg::OP_ENQ, 32'h5555_5555);
      send(0, 0, fqd_pkg::OP_DEL, fqd_pkg::VALUE_W'(32'h1000 + CAPACITY));
      send(0, 0, fqd_pkg::OP_DEL, 32'h8000_0000);
      send(0, 0, fqd_pkg::OP_DEL, 32'h0000_1008);
      send(0, 0, fqd_pkg::OP_LEN, '0);
      drain_wait();

      for (int p = 0; p < 3; p++) begin
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ((i / 40) % 3)
               0: enq_bias = 70;
               1: enq_bias = 25;
               default: enq_bias = 45;
            endcase
            send(idle_pct[p], 1, fqd_pkg::OP_LEN, '0);
         end
         drain_wait();
      end

      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.expected.size() == 0)
         $display("fifo_queue_with_delete_tb: clean");
      else
         $display("fifo_queue_with_delete_tb: errors");
      $finish;
   end

endmodule
